@@ rtl/core/csr_sparse_matrix_store_spmv_unit_defines.svh @@
// ----------------------------------------------------------------------------
// CSR SpMV assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef CSR_SPARSE_MATRIX_STORE_SPMV_UNIT_DEFINES_SVH
`define CSR_SPARSE_MATRIX_STORE_SPMV_UNIT_DEFINES_SVH
// implication, checked out of reset
`define CSR_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication, checked out of reset
`define CSR_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

@@ rtl/core/csr_pkg.sv @@
// ----------------------------------------------------------------------------
// CSR SpMV package
// Sizes, opcodes and status codes of the sparse matrix store.
// ----------------------------------------------------------------------------
package csr_pkg;
	localparam int MAX_ROWS    = 256;
	localparam int MAX_COLS    = 256;
	localparam int MAX_ENTRIES = 4096;
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ENT_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = ENT_W + 1;

	typedef enum logic [1:0] {
		OP_SET = 2'd0, OP_GET = 2'd1, OP_LOAD = 2'd2, OP_PROD = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_RANGE = 2'd1, ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic clr;
		logic acc;
	} mac_ctl_t;
endpackage

@@ rtl/core/csr_mac.sv @@
// ----------------------------------------------------------------------------
// CSR multiply-accumulate unit
// Shared 32x32 multiplier with a registered product and a wide exact sum.
// ----------------------------------------------------------------------------
module csr_mac import csr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  mac_ctl_t           ctl,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [31:0] sat
);
	logic signed [63:0] prod_s1;
	logic               vld_s1;
	logic signed [76:0] acc_q;
	logic signed [60:0] shf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctl.acc;
			if (ctl.clr) acc_q <= '0;
			else if (vld_s1) acc_q <= acc_q + 77'(prod_s1);
		end
	end

	always_ff @(posedge clk) prod_s1 <= a * b;

	assign shf = acc_q[76:16];
	always_comb begin
		if (shf > 61'sd2147483647) sat = 32'sh7fffffff;
		else if (shf < -61'sd2147483648) sat = 32'sh80000000;
		else sat = shf[31:0];
	end
endmodule

@@ rtl/core/csr_sparse_matrix_store_spmv_unit.sv @@
// ----------------------------------------------------------------------------
// CSR sparse matrix store with row product
// Compressed-row store, dense vector, and sequencer over one shared MAC.
// ----------------------------------------------------------------------------
// channel  | handshake              | fields
// command  | start / busy           | opcode row_index col_index data_value
// result   | done (one cycle)       | result_value status
// config   | cfg_valid / cfg_ready  | cfg_index cfg_data
// Load writes the vector entry; get and set search the row entry by entry.
// Insertion shifts every later entry, then bumps the row pointers after the
// row. Row product multiplies and sums the entries of the row.
// After reset the row pointer and vector memories are swept, with busy
// high. Results cannot be stalled.
module csr_sparse_matrix_store_spmv_unit import csr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [7:0]         row_index,
	input  logic [7:0]         col_index,
	input  logic signed [31:0] data_value,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [8:0]         cfg_data
);
	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_PTR0, S_PTR1, S_RD, S_CHK, S_SHRD, S_SHWR,
		S_PUT, S_BUMP, S_PRD, S_PMUL, S_PWAIT, S_LOAD, S_DONE
	} state_t;

	state_t state_q;
	logic [8:0] rows_q, cols_q;
	logic [1:0] op_q;
	logic [ROW_W-1:0] r_q;
	logic [COL_W-1:0] c_q;
	logic signed [31:0] v_q, res_q;
	logic [1:0] st_q;
	logic [CNT_W-1:0] cnt_q, b_q, e_q, i_q;
	logic [8:0] k_q;
	logic fnd_q, bw_q;

	logic [CNT_W-1:0] rs_mem [MAX_ROWS+1];
	logic [COL_W-1:0] col_mem [MAX_ENTRIES];
	logic signed [31:0] val_mem [MAX_ENTRIES];
	logic signed [31:0] x_mem [MAX_COLS];
	logic [CNT_W-1:0] rs_rd;
	logic [COL_W-1:0] col_rd;
	logic signed [31:0] val_rd, x_rd;
	logic [8:0] rs_addr;
	logic rs_we;
	logic [CNT_W-1:0] rs_wd;
	logic [ENT_W-1:0] ent_ra;
	logic ent_we;
	logic [ENT_W-1:0] ent_wa;
	logic [COL_W-1:0] ent_wc;
	logic signed [31:0] ent_wv;
	logic x_we;
	logic [COL_W-1:0] x_wa;
	logic signed [31:0] x_wd;
	mac_ctl_t mctl;
	logic signed [31:0] sat;
	logic [8:0] rlim, clim;

	assign rlim = (rows_q > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : rows_q;
	assign clim = (cols_q > 9'(MAX_COLS)) ? 9'(MAX_COLS) : cols_q;
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (rs_we) rs_mem[rs_addr] <= rs_wd;
		rs_rd <= rs_mem[rs_addr];
		if (ent_we) begin
			col_mem[ent_wa] <= ent_wc;
			val_mem[ent_wa] <= ent_wv;
		end
		col_rd <= col_mem[ent_ra];
		val_rd <= val_mem[ent_ra];
		if (x_we) x_mem[x_wa] <= x_wd;
		x_rd <= x_mem[col_rd];
	end

	csr_mac u_mac (.clk, .arst_n, .ctl(mctl), .a(val_rd), .b(x_rd), .sat);

	always_comb begin
		rs_addr = 9'(r_q);
		rs_we = 1'b0;
		rs_wd = rs_rd + 1'b1;
		ent_ra = i_q[ENT_W-1:0];
		ent_we = 1'b0;
		ent_wa = i_q[ENT_W-1:0];
		ent_wc = col_rd;
		ent_wv = val_rd;
		x_we = 1'b0;
		x_wa = c_q;
		x_wd = v_q;
		mctl = '0;
		unique case (state_q)
			S_CLR: begin
				rs_addr = k_q; rs_we = 1'b1; rs_wd = '0;
				x_we = 1'b1; x_wa = k_q[COL_W-1:0]; x_wd = '0;
			end
			S_PTR0: rs_addr = 9'(r_q);
			S_PTR1: rs_addr = 9'(r_q) + 9'd1;
			S_SHRD: ent_ra = i_q[ENT_W-1:0] - 1'b1;
			S_SHWR: ent_we = 1'b1;
			S_PUT: begin
				ent_we = 1'b1; ent_wc = c_q; ent_wv = v_q;
				if (op_q == OP_SET && st_q == ST_OK && !(b_q != i_q)) ent_wa = i_q[ENT_W-1:0];
			end
			S_BUMP: rs_addr = k_q;
			S_LOAD: x_we = 1'b1;
			S_PMUL: mctl.acc = 1'b1;
			S_IDLE: mctl.clr = 1'b1;
			default: ;
		endcase
		if (state_q == S_BUMP && bw_q) begin
			rs_addr = k_q; rs_we = 1'b1; rs_wd = rs_rd + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			rows_q <= 9'd256;
			cols_q <= 9'd256;
			cnt_q <= '0;
			k_q <= '0;
			done <= 1'b0;
			fnd_q <= 1'b0;
			bw_q <= 1'b0;
		end else begin
			done <= (state_q == S_DONE);
			if (cfg_valid) begin
				if (cfg_index == 1'b0) rows_q <= cfg_data;
				else cols_q <= cfg_data;
			end
			unique case (state_q)
				S_CLR: begin
					k_q <= k_q + 9'd1;
					if (k_q == 9'(MAX_ROWS)) state_q <= S_IDLE;
				end
				S_IDLE: if (start) begin
					op_q <= opcode; r_q <= row_index; c_q <= col_index; v_q <= data_value;
					res_q <= '0; st_q <= ST_OK; fnd_q <= 1'b0;
					if (opcode == OP_LOAD) begin
						if (9'(col_index) >= clim) begin st_q <= ST_RANGE; state_q <= S_DONE; end
						else state_q <= S_LOAD;
					end else if (9'(row_index) >= rlim ||
						(opcode != OP_PROD && 9'(col_index) >= clim)) begin
						st_q <= ST_RANGE; state_q <= S_DONE;
					end else state_q <= S_PTR0;
				end
				S_LOAD: state_q <= S_DONE;
				S_PTR0: state_q <= S_PTR1;
				S_PTR1: begin b_q <= rs_rd; i_q <= rs_rd; state_q <= S_RD; end
				S_RD: begin
					if (!bw_q) begin e_q <= rs_rd; bw_q <= 1'b1; end
					state_q <= (op_q == OP_PROD) ? S_PRD : S_CHK;
				end
				S_CHK: begin
					// col_rd/val_rd hold entry i_q
					if (i_q >= e_q) begin
						bw_q <= 1'b0;
						if (op_q == OP_GET) state_q <= S_DONE;
						else if (v_q == 0) state_q <= S_DONE;
						else if (cnt_q >= CNT_W'(MAX_ENTRIES)) begin
							st_q <= ST_FULL; state_q <= S_DONE;
						end else begin b_q <= i_q; i_q <= cnt_q; state_q <= S_SHRD; end
					end else if (col_rd == c_q) begin
						bw_q <= 1'b0;
						if (op_q == OP_GET) begin res_q <= val_rd; state_q <= S_DONE; end
						else begin fnd_q <= 1'b1; b_q <= i_q; state_q <= S_PUT; end
					end else if (col_rd > c_q) begin
						bw_q <= 1'b0;
						if (op_q == OP_GET || v_q == 0) state_q <= S_DONE;
						else if (cnt_q >= CNT_W'(MAX_ENTRIES)) begin
							st_q <= ST_FULL; state_q <= S_DONE;
						end else begin b_q <= i_q; i_q <= cnt_q; state_q <= S_SHRD; end
					end else begin i_q <= i_q + 1'b1; state_q <= S_RD; end
				end
				S_SHRD: begin
					if (i_q == b_q) state_q <= S_PUT;
					else state_q <= S_SHWR;
				end
				S_SHWR: begin i_q <= i_q - 1'b1; state_q <= S_SHRD; end
				S_PUT: begin
					if (fnd_q) state_q <= S_DONE;
					else begin
						cnt_q <= cnt_q + 1'b1; k_q <= 9'(MAX_ROWS); state_q <= S_BUMP;
					end
				end
				S_BUMP: begin
					// read pointer k this cycle, write it the next with k kept
					if (bw_q) begin
						bw_q <= 1'b0;
						if (k_q == 9'(r_q) + 9'd1) state_q <= S_DONE;
						else k_q <= k_q - 9'd1;
					end else bw_q <= 1'b1;
				end
				S_PRD: begin
					if (i_q >= e_q) begin bw_q <= 1'b0; state_q <= S_PWAIT; end
					else state_q <= S_PMUL;
				end
				S_PMUL: begin i_q <= i_q + 1'b1; state_q <= S_RD; end
				S_PWAIT: begin
					if (bw_q) begin bw_q <= 1'b0; res_q <= sat; state_q <= S_DONE; end
					else bw_q <= 1'b1;
				end
				S_DONE: begin
					result_value <= res_q; status <= st_q;
					bw_q <= 1'b0; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/csr_checker.sv @@
// ----------------------------------------------------------------------------
// CSR SpMV port checker
// Port-level properties of the command and result channels.
// ----------------------------------------------------------------------------
`include "csr_sparse_matrix_store_spmv_unit_defines.svh"
module csr_checker import csr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic signed [31:0] result_value,
	input logic [1:0] status
);
	`CSR_ASSERT_NEXT(a_take_busy, clk, arst_n, start && !busy, busy)
	`CSR_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	`CSR_ASSERT_IMPL(a_err_zero, clk, arst_n, done && status != ST_OK, result_value == 0)
	`CSR_ASSERT_NEXT(a_done_once, clk, arst_n, done, !done)
endmodule

bind csr_sparse_matrix_store_spmv_unit csr_checker u_chk (
	.clk, .arst_n, .start, .busy, .done, .result_value, .status
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse matrix store testbench
// Drives set, get, vector-load and row-product commands into the compressed-
// row store under changing row and column limits. Every result is checked
// against an in-bench model of the store, the vector and the saturated
// Q16.16 dot product.
// ----------------------------------------------------------------------------
module testbench;
	import csr_pkg::*;

	localparam int LIMIT = 20000000;

	typedef struct packed {
		op_t               op;
		logic [7:0]        row;
		logic [7:0]        col;
		logic signed [31:0] val;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] val;
		status_t            st;
	} answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         opcode = '0;
	logic [7:0]         row_index = '0;
	logic [7:0]         col_index = '0;
	logic signed [31:0] data_value = '0;
	logic               done;
	logic signed [31:0] result_value;
	logic [1:0]         status;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_index = 1'b0;
	logic [8:0]         cfg_data = '0;

	cmd_t    pending_cmds[$];
	answer_t expected_answers[$];
	int      errors = 0;
	int      checked = 0;
	int      cycles = 0;
	int      send_idle_pct = 0;
	int      full_seen = 0;
	int      range_seen = 0;

	// model state
	int                 m_rows = 256;
	int                 m_cols = 256;
	int                 m_row_start[MAX_ROWS + 1];
	logic [7:0]         m_col[MAX_ENTRIES];
	logic signed [31:0] m_val[MAX_ENTRIES];
	int                 m_count = 0;
	logic signed [31:0] m_x[MAX_COLS];

	csr_sparse_matrix_store_spmv_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .row_index(row_index), .col_index(col_index),
		.data_value(data_value), .done(done), .result_value(result_value),
		.status(status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic signed [31:0] row_dot(int r);
		logic signed [95:0] acc;
		logic signed [95:0] q;
		acc = '0;
		for (int i = m_row_start[r]; i < m_row_start[r + 1]; i++)
			acc += 96'(64'(m_val[i]) * 64'(m_x[m_col[i]]));
		q = acc >>> 16;
		if (q > 96'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (q < -96'sh8000_0000) return 32'sh8000_0000;
		return q[31:0];
	endfunction

	function automatic answer_t apply_cmd(cmd_t c);
		answer_t a;
		int b, e, pos;
		bit found;
		a.val = '0;
		a.st = ST_OK;
		if (c.op == OP_LOAD) begin
			if (c.col >= m_cols) a.st = ST_RANGE;
			else m_x[c.col] = c.val;
		end else if (c.op == OP_PROD) begin
			if (c.row >= m_rows) a.st = ST_RANGE;
			else a.val = row_dot(c.row);
		end else if (c.row >= m_rows || c.col >= m_cols) begin
			a.st = ST_RANGE;
		end else begin
			b = m_row_start[c.row];
			e = m_row_start[c.row + 1];
			found = 0;
			pos = b;
			while (pos < e && m_col[pos] < c.col) pos++;
			if (pos < e && m_col[pos] == c.col) found = 1;
			if (c.op == OP_GET) begin
				if (found) a.val = m_val[pos];
			end else if (found) begin
				m_val[pos] = c.val;
			end else if (c.val != 0) begin
				if (m_count >= MAX_ENTRIES) begin
					a.st = ST_FULL;
				end else begin
					for (int k = m_count; k > pos; k--) begin
						m_col[k] = m_col[k - 1];
						m_val[k] = m_val[k - 1];
					end
					m_col[pos] = c.col;
					m_val[pos] = c.val;
					for (int k = c.row + 1; k <= MAX_ROWS; k++) m_row_start[k]++;
					m_count++;
				end
			end
		end
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %0s at cycle %0d: got %h expected %h", what, cycles, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (!start || !busy) begin
			if (start) begin
				answer_t a;
				a = apply_cmd('{op_t'(opcode), row_index, col_index, data_value});
				expected_answers.insert(expected_answers.size(), a);
			end
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd_t c;
				c = pending_cmds.pop_front();
				start <= 1'b1;
				opcode <= c.op;
				row_index <= c.row;
				col_index <= c.col;
				data_value <= c.val;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				report_mismatch("unexpected result", result_value, '0);
			end else begin
				answer_t a;
				a = expected_answers.pop_front();
				checked++;
				if (a.st == ST_FULL) full_seen++;
				if (a.st == ST_RANGE) range_seen++;
				if (result_value !== a.val) report_mismatch("result_value", result_value, a.val);
				if (status !== a.st) report_mismatch("status", status, a.st);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic drain();
		while (pending_cmds.size() != 0 || start || expected_answers.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [8:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == 1'b0) m_rows = (data > MAX_ROWS) ? MAX_ROWS : data;
		else m_cols = (data > MAX_COLS) ? MAX_COLS : data;
	endtask

	task automatic push_cmd(op_t op, int r, int c, logic signed [31:0] v);
		cmd_t item;
		item = '{op, 8'(r), 8'(c), v};
		pending_cmds.insert(pending_cmds.size(), item);
	endtask

	task automatic push_random(int n);
		int r, c;
		logic signed [31:0] v;
		for (int i = 0; i < n; i++) begin
			r = ($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(255);
			c = ($urandom_range(99) < 70) ? $urandom_range(15) : $urandom_range(255);
			case ($urandom_range(3))
				0: v = 0;
				1: v = $signed(32'($urandom_range(65535))) - 32768;
				default: v = $urandom;
			endcase
			push_cmd(op_t'($urandom_range(3)), r, c, v);
		end
	endtask

	initial begin
		for (int i = 0; i <= MAX_ROWS; i++) m_row_start[i] = 0;
		for (int i = 0; i < MAX_COLS; i++) m_x[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(1'b0, 9'd256);
		write_reg(1'b1, 9'd256);
		push_cmd(OP_SET, 0, 0, 32'sh7FFF_FFFF);
		push_cmd(OP_SET, 0, 255, 32'sh8000_0000);
		push_cmd(OP_SET, 255, 255, 32'sh0000_0001);
		push_cmd(OP_SET, 255, 0, 32'sh1234_5678);
		push_cmd(OP_SET, 5, 5, 32'sh0);
		push_cmd(OP_GET, 5, 5, 32'sh0);
		push_cmd(OP_GET, 0, 0, 32'sh0);
		push_cmd(OP_GET, 0, 255, 32'sh0);
		push_cmd(OP_GET, 255, 255, 32'sh0);
		push_cmd(OP_LOAD, 0, 0, 32'sh7FFF_FFFF);
		push_cmd(OP_LOAD, 0, 255, 32'sh8000_0000);
		push_cmd(OP_PROD, 0, 0, 32'sh0);
		push_cmd(OP_PROD, 255, 0, 32'sh0);
		push_cmd(OP_PROD, 10, 0, 32'sh0);
		push_cmd(OP_LOAD, 0, 255, 32'sh7FFF_FFFF);
		push_cmd(OP_PROD, 0, 0, 32'sh0);
		push_cmd(OP_LOAD, 0, 0, 32'sh0001_0000);
		push_cmd(OP_PROD, 255, 0, 32'sh0);
		push_cmd(OP_SET, 0, 0, 32'sh0);
		push_cmd(OP_GET, 0, 0, 32'sh0);
		push_cmd(OP_PROD, 0, 0, 32'sh0);
		drain();

		// shrunk limits, entries beyond them stay in use by row products
		write_reg(1'b0, 9'd40);
		write_reg(1'b1, 9'd48);
		send_idle_pct = 18;
		push_cmd(OP_PROD, 0, 0, 32'sh0);
		push_cmd(OP_SET, 40, 0, 32'sh1);
		push_cmd(OP_GET, 0, 48, 32'sh0);
		push_cmd(OP_LOAD, 0, 48, 32'sh1);
		push_random(300);
		drain();

		// values above the maximum are capped
		write_reg(1'b0, 9'd511);
		write_reg(1'b1, 9'd300);
		send_idle_pct = 60;
		push_random(300);
		drain();

		write_reg(1'b0, 9'd0);
		write_reg(1'b1, 9'd0);
		send_idle_pct = 0;
		push_random(20);
		drain();

		write_reg(1'b0, 9'd256);
		write_reg(1'b1, 9'd256);
		push_random(230);
		drain();

		send_idle_pct = 18;
		for (int i = 0; i < 6; i++) begin
			push_cmd(OP_SET, 255, 255 - i, 32'sh0001_0000);
			push_cmd(OP_SET, 200, 255 - i, 32'sh0);
			push_cmd(OP_GET, $urandom_range(15), $urandom_range(255), 32'sh0);
			push_cmd(OP_PROD, $urandom_range(15), 0, 32'sh0);
			push_cmd(OP_SET, 0, i, $urandom);
		end
		drain();

		$display("checked %0d results over %0d cycles: %0d range errors, %0d store-full",
			checked, cycles, range_seen, full_seen);
		$display("limits swept from zero to above maximum; store holds %0d entries",
			m_count);
		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/csr_pkg.sv
rtl/core/csr_mac.sv
rtl/core/csr_sparse_matrix_store_spmv_unit.sv
rtl/core/csr_checker.sv
sim/testbench.sv
